// ===== design/wrp_pkg.sv =====
// shared types, constants and the field window lookup for the weather record parser
// no dependencies; used by every module of the block
`default_nettype none

package wrp_pkg;

    localparam int FIELD_COUNT = 8;
    localparam int POS_W       = 6;
    localparam int ACC_W       = 18;
    localparam int VAL_W       = 32;
    localparam int IDX_W       = 3;

    localparam logic [POS_W-1:0] POS_MAX       = 6'd63;
    localparam logic [POS_W-1:0] LEN_PLAIN     = 6'd33;
    localparam logic [POS_W-1:0] LEN_WITH_CRLF = 6'd35;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [POS_W-1:0] FIELD_START [FIELD_COUNT] = '{
        6'd1, 6'd5, 6'd9, 6'd13, 6'd17, 6'd21, 6'd25, 6'd28
    };
    localparam logic [POS_W-1:0] FIELD_LEN [FIELD_COUNT] = '{
        6'd3, 6'd3, 6'd3, 6'd3, 6'd3, 6'd3, 6'd2, 6'd5
    };
    localparam logic [VAL_W-1:0] FIELD_MASK [FIELD_COUNT] = '{
        32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF,
        32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_00FF, 32'hFFFF_FFFF
    };

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

    typedef struct packed {
        t_phase             phase;
        logic [ACC_W-1:0]   acc;
        logic               neg;
    } t_field_state;

    localparam t_field_state FIELD_CLEAR = '{phase: PH_SKIP, acc: '0, neg: 1'b0};

    typedef struct packed {
        logic               hit;
        logic               first;
        logic [IDX_W-1:0]   idx;
    } t_field_hit;

    typedef logic [FIELD_COUNT-1:0][VAL_W-1:0] t_fields;

    // which field window a byte position falls in, if any
    function automatic t_field_hit find_field(input logic [POS_W-1:0] pos);
        t_field_hit h;
        h = '{hit: 1'b0, first: 1'b0, idx: '0};
        for (int i = 0; i < FIELD_COUNT; i++) begin
            if (pos >= FIELD_START[i] && pos < POS_W'(FIELD_START[i] + FIELD_LEN[i])) begin
                h.hit   = 1'b1;
                h.first = (pos == FIELD_START[i]);
                h.idx   = IDX_W'(i);
            end
        end
        return h;
    endfunction

endpackage

`default_nettype wire

// ===== design/wrp_char_parse.sv =====
// atoi step for one character of a field: whitespace skip, sign, digit accumulate
// depends on wrp_pkg
`default_nettype none

module wrp_char_parse
    import wrp_pkg::*;
(
    input  wire t_field_state  i_state,
    input  wire                i_restart,
    input  wire logic [7:0]    i_char,
    output t_field_state       o_state
);

    t_field_state     w_cur;
    logic             w_digit;
    logic             w_space;
    logic [ACC_W-1:0] w_dval;
    logic [ACC_W+3:0] w_times_ten;

    always_comb begin
        w_cur       = i_restart ? FIELD_CLEAR : i_state;
        w_digit     = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
        w_space     = (i_char == CH_SPACE) || ((i_char >= CH_TAB) && (i_char <= CH_CR));
        w_dval      = ACC_W'(i_char - CH_ZERO);
        // acc * 10 as two shifts
        w_times_ten = ({4'b0, w_cur.acc} << 3) + ({4'b0, w_cur.acc} << 1);
        o_state     = w_cur;
        case (w_cur.phase)
            PH_SKIP: begin
                if (w_space) begin
                    o_state = w_cur;
                end else if (i_char == CH_PLUS || i_char == CH_MINUS) begin
                    o_state.neg   = (i_char == CH_MINUS);
                    o_state.phase = PH_DIGITS;
                end else if (w_digit) begin
                    o_state.acc   = w_dval;
                    o_state.phase = PH_DIGITS;
                end else begin
                    o_state.phase = PH_DONE;
                end
            end
            PH_DIGITS: begin
                if (w_digit) begin
                    o_state.acc = w_times_ten[ACC_W-1:0] + w_dval;
                end else begin
                    o_state.phase = PH_DONE;
                end
            end
            default: begin
                o_state = w_cur;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/wrp_record_core.sv =====
// record state: byte position, field parse state, pending and committed field values
// depends on wrp_pkg and wrp_char_parse
`default_nettype none

module wrp_record_core
    import wrp_pkg::*;
(
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    input  wire logic [7:0] i_char,
    input  wire             i_last,
    output logic            o_ok,
    output t_fields         o_fields
);

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    t_field_state     r_field;
    t_field_state     w_parsed;
    t_fields          r_pending;
    t_fields          r_committed;
    t_field_hit       w_hit;
    logic             w_in_range;
    logic [VAL_W-1:0] w_mag;
    logic [VAL_W-1:0] w_val;

    assign w_in_range = (r_pos < POS_MAX);
    assign w_hit      = find_field(r_pos);

    wrp_char_parse u_parse (
        .i_state   (r_field),
        .i_restart (w_hit.first),
        .i_char    (i_char),
        .o_state   (w_parsed)
    );

    always_comb begin
        n_pos = w_in_range ? r_pos + 6'd1 : r_pos;
        w_mag = {{(VAL_W-ACC_W){1'b0}}, w_parsed.acc};
        w_val = (w_parsed.neg ? (VAL_W'(0) - w_mag) : w_mag) & FIELD_MASK[w_hit.idx];
        o_ok  = (n_pos == LEN_PLAIN) || (n_pos == LEN_WITH_CRLF);
        // fields as they stand after this word's commit
        o_fields = o_ok ? r_pending : r_committed;
        if (o_ok && w_in_range && w_hit.hit) begin
            o_fields[w_hit.idx] = w_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_field     <= FIELD_CLEAR;
            r_pending   <= '0;
            r_committed <= '0;
        end else if (i_valid) begin
            if (w_in_range && w_hit.hit) begin
                r_field               <= w_parsed;
                r_pending[w_hit.idx]  <= w_val;
            end
            if (i_last) begin
                r_pos   <= '0;
                r_field <= FIELD_CLEAR;
                if (o_ok) begin
                    r_committed <= o_fields;
                end
            end else begin
                r_pos <= n_pos;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/weather_record_field_parser.sv =====
// Weather record field parser. One ASCII character of a fixed-layout sensor record is taken
// per word; tlast marks the final character. Eight decimal fields (atoi rules) are read at
// byte offsets 1, 5, 9, 13, 17, 21, 25 and 28. On the final character one result word is
// sent: tuser is 1 when the record length was 33 or 35 and the fields were updated, else 0
// and the previous record is repeated. A character passes an input register and one step of
// parse logic into the output register, so the block takes one word per clock; it stalls only
// when a final character meets a full output register that is not being drained.
// depends on wrp_pkg and wrp_record_core
`default_nettype none

module weather_record_field_parser
    import wrp_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  wire [7:0]    i_s_axis_tdata,   // byte_in
    input  wire          i_s_axis_tlast,   // last_byte
    output logic         o_m_axis_tvalid,
    input  wire          i_m_axis_tready,
    // wind_direction, wind_speed_one_min, wind_speed_five_min, temperature_value,
    // rain_one_hour, rain_one_day (16 each), humidity_value (8), air_pressure (32)
    output logic [135:0] o_m_axis_tdata,
    output logic         o_m_axis_tuser    // ok
);

    logic         r_in_valid;
    logic [7:0]   r_in_char;
    logic         r_in_last;
    logic         r_out_valid;
    logic [135:0] r_out_data;
    logic         r_out_ok;
    logic         w_adv;
    logic         w_fire;
    logic         w_ok;
    t_fields      w_fields;

    // only a final character needs room in the output register
    assign w_adv           = !r_in_last || !r_out_valid || i_m_axis_tready;
    assign w_fire          = r_in_valid && w_adv;
    assign o_s_axis_tready = !r_in_valid || w_adv;

    wrp_record_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_fire),
        .i_char   (r_in_char),
        .i_last   (r_in_last),
        .o_ok     (w_ok),
        .o_fields (w_fields)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_char <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_in_last) begin
            r_out_ok   <= w_ok;
            r_out_data <= {w_fields[7], w_fields[6][7:0],
                           w_fields[5][15:0], w_fields[4][15:0], w_fields[3][15:0],
                           w_fields[2][15:0], w_fields[1][15:0], w_fields[0][15:0]};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_ok;

endmodule

`default_nettype wire
